@@ hw/rtl/bucket_select_pass_defines.svh @@
// ----------------------------------------------------------------------------
// bucket_select_pass_defines
// Assertion macros used by bsp_back of the bucket select pass RTL.
// ----------------------------------------------------------------------------
`ifndef BUCKET_SELECT_PASS_DEFINES_SVH
`define BUCKET_SELECT_PASS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and constants of the bucket select pass block.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_BEGIN  = 2'd0,
        CFG_RANGE_END    = 2'd1,
        CFG_BUCKET_COUNT = 2'd2,
        CFG_TARGET_RANK  = 2'd3
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_RANGE_BEGIN  = 32'd0;
    localparam logic [31:0] RST_RANGE_END    = 32'd2147483647;
    localparam logic [8:0]  RST_BUCKET_COUNT = 9'd256;
    localparam logic [31:0] RST_TARGET_RANK  = 32'd1;

    // Saturation value of a bucket counter
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Last step of the 32-step restoring divider
    localparam logic [4:0] DIV_LAST = 5'd31;

    // Input beat
    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [7:0]  target_bucket;
        logic [31:0] rank_in_bucket;
        logic [31:0] bucket_size;
        logic [31:0] sub_range_begin;
        logic [31:0] sub_range_end;
        logic        found;
    } t_out_item;

endpackage

@@ hw/rtl/bsp_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bsp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bsp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/bsp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_front
// Accept values, latch the bucket width per pass, classify each value into
// its bucket with a shared bit-serial divider and push it to the queue.
// ----------------------------------------------------------------------------
module bsp_front #(
    parameter int IDX_W = 8,
    parameter int QW    = IDX_W + 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsp_chan_if.sink          i_in_ch,
    input  logic [31:0]       i_range_begin,
    input  logic [31:0]       i_range_end,
    input  logic [IDX_W-1:0]  i_last_idx,
    input  logic              i_clearing,
    input  logic              i_q_full,
    output logic              o_push,
    output logic [QW-1:0]     o_entry
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WDIV = 4'b0010,
        ST_IDIV = 4'b0100,
        ST_PUSH = 4'b1000
    } t_front_state;

    t_front_state     r_state;
    logic             r_pass_open;
    logic             r_last;
    logic [31:0]      r_diff;
    logic [31:0]      r_width;
    logic [31:0]      r_rem;
    logic [31:0]      r_quo;
    logic [31:0]      r_div;
    logic [4:0]       r_cnt;
    logic [IDX_W-1:0] r_bidx;

    logic [31:0] w_n;
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_rem_nx;
    logic [31:0] w_quo_nx;
    logic [31:0] w_width_nx;
    logic        w_accept;

    assign w_n = 32'(i_last_idx) + 32'd1;
    assign i_in_ch.ready = (r_state == ST_IDLE) && !i_clearing;
    assign w_accept = i_in_ch.valid && i_in_ch.ready;

    // One restoring division step
    assign w_trial    = {r_rem, r_quo[31]};
    assign w_ge       = w_trial >= {1'b0, r_div};
    assign w_rem_nx   = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    assign w_quo_nx   = {r_quo[30:0], w_ge};
    assign w_width_nx = (w_quo_nx == 32'd0) ? 32'd1 : w_quo_nx;

    assign o_push  = (r_state == ST_PUSH) && !i_q_full;
    assign o_entry = {r_bidx, r_last, r_width};

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass_open <= 1'b0;
            r_cnt       <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_state <= r_pass_open ? ST_IDIV : ST_WDIV;
                    end
                end
                ST_WDIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == bsp_pkg::DIV_LAST) begin
                        r_pass_open <= 1'b1;
                        r_state     <= ST_IDIV;
                    end
                end
                ST_IDIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == bsp_pkg::DIV_LAST) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (o_push) begin
                        if (r_last) begin
                            r_pass_open <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Divider datapath and classification
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            if (w_accept) begin
                r_last <= i_in_ch.data.last;
                r_diff <= i_in_ch.data.value - i_range_begin;
                r_rem  <= '0;
                if (r_pass_open) begin
                    r_quo <= i_in_ch.data.value - i_range_begin;
                    r_div <= r_width;
                end else begin
                    r_quo <= i_range_end - i_range_begin;
                    r_div <= w_n;
                end
            end
        end else if (r_state == ST_WDIV) begin
            if (r_cnt == bsp_pkg::DIV_LAST) begin
                // Latch width and restart on the value offset
                r_width <= w_width_nx;
                r_div   <= w_width_nx;
                r_quo   <= r_diff;
                r_rem   <= '0;
            end else begin
                r_rem <= w_rem_nx[31:0];
                r_quo <= w_quo_nx;
            end
        end else if (r_state == ST_IDIV) begin
            r_rem <= w_rem_nx[31:0];
            r_quo <= w_quo_nx;
            if (r_cnt == bsp_pkg::DIV_LAST) begin
                // Clamp to the last bucket in use
                r_bidx <= (w_quo_nx >= w_n) ? i_last_idx : w_quo_nx[IDX_W-1:0];
            end
        end
    end
endmodule

@@ hw/rtl/bsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_queue
// Two-entry queue between the classifier and the histogram engine.
// ----------------------------------------------------------------------------
module bsp_queue #(
    parameter int W = 41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end
endmodule

@@ hw/rtl/bsp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_back
// Histogram engine: count each classified value, scan for the wanted rank on
// the last value, emit the result and sweep the histogram clear.
// ----------------------------------------------------------------------------
`include "bucket_select_pass_defines.svh"

module bsp_back #(
    parameter int NUM_BUCKETS = 256,
    parameter int IDX_W       = 8,
    parameter int QW          = IDX_W + 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [QW-1:0]    i_entry,
    output logic             o_pop,
    input  logic [31:0]      i_range_begin,
    input  logic [31:0]      i_target_rank,
    input  logic [IDX_W-1:0] i_last_idx,
    output logic             o_clearing,
    bsp_chan_if.source       o_out_ch
);
    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_UPD_RD   = 8'b0000_0100,
        ST_UPD_WR   = 8'b0000_1000,
        ST_SCAN_RD  = 8'b0001_0000,
        ST_SCAN_CHK = 8'b0010_0000,
        ST_MULT     = 8'b0100_0000,
        ST_RES      = 8'b1000_0000
    } t_back_state;

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(NUM_BUCKETS - 1);

    t_back_state        r_state;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_bidx;
    logic               r_last;
    logic [31:0]        r_width;
    logic [32:0]        r_running;
    logic [31:0]        r_prefix;
    logic [31:0]        r_rank;
    logic [IDX_W-1:0]   r_target;
    logic [31:0]        r_size;
    logic               r_found;
    logic [31:0]        r_prod;
    logic               r_out_valid;
    bsp_pkg::t_out_item r_out;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [31:0]      w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [31:0]      w_rdata;
    logic [32:0]      w_run_nx;
    logic             w_hit;
    logic             w_load;
    logic [31:0]      w_sub_begin;

    bsp_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BUCKETS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_clearing = (r_state == ST_CLEAR);

    // Select memory ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = '0;
        w_raddr = r_i;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_UPD_RD) begin
            w_raddr = r_bidx;
        end else if (r_state == ST_UPD_WR) begin
            w_we    = 1'b1;
            w_waddr = r_bidx;
            w_wdata = (w_rdata == bsp_pkg::CNT_MAX) ? w_rdata : (w_rdata + 32'd1);
        end
    end

    // Running count for the rank scan
    assign w_run_nx = r_running + {1'b0, w_rdata};
    assign w_hit    = w_run_nx >= {1'b0, r_rank};

    // Load result when the output register is free or being drained
    assign w_load      = (r_state == ST_RES) && (!r_out_valid || o_out_ch.ready);
    assign w_sub_begin = i_range_begin + r_prod;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_i <= r_i + IDX_W'(1);
                    if (r_i == LAST_ENTRY) begin
                        r_i     <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_UPD_RD;
                    end
                end
                ST_UPD_RD: r_state <= ST_UPD_WR;
                ST_UPD_WR: begin
                    r_i     <= '0;
                    r_state <= r_last ? ST_SCAN_RD : ST_IDLE;
                end
                ST_SCAN_RD: r_state <= ST_SCAN_CHK;
                ST_SCAN_CHK: begin
                    if (w_hit || (r_i == i_last_idx)) begin
                        r_state <= ST_MULT;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_MULT: r_state <= ST_RES;
                ST_RES: begin
                    if (w_load) begin
                        r_i     <= '0;
                        r_state <= ST_CLEAR;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Pass datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bidx  <= i_entry[QW-1:33];
            r_last  <= i_entry[32];
            r_width <= i_entry[31:0];
        end
        if (r_state == ST_UPD_WR) begin
            r_running <= '0;
            r_rank    <= (i_target_rank == 32'd0) ? 32'd1 : i_target_rank;
        end
        if (r_state == ST_SCAN_CHK) begin
            r_prefix  <= r_running[31:0];
            r_running <= w_run_nx;
            r_target  <= r_i;
            r_size    <= w_rdata;
            r_found   <= w_hit;
        end
        if (r_state == ST_MULT) begin
            r_prod <= r_width * 32'(r_target);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.target_bucket   <= 8'(r_target);
            r_out.rank_in_bucket  <= r_rank - r_prefix;
            r_out.bucket_size     <= r_size;
            r_out.sub_range_begin <= w_sub_begin;
            r_out.sub_range_end   <= w_sub_begin + r_width;
            r_out.found           <= r_found;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    `BSP_ASSERT_IMP(a_found_rank_bounds, i_clk, i_rst_n,
        r_out_valid && r_out.found,
        (r_out.rank_in_bucket != 32'd0) && (r_out.rank_in_bucket <= r_out.bucket_size),
        "found result with rank outside its bucket")
    `BSP_ASSERT_IMP(a_result_from_res, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == ST_RES),
        "result raised outside the result state")
    `BSP_ASSERT_NXT(a_scan_flow, i_clk, i_rst_n,
        r_state == ST_SCAN_CHK, (r_state == ST_SCAN_RD) || (r_state == ST_MULT),
        "scan left its loop unexpectedly")
endmodule

@@ hw/rtl/bucket_select_pass.sv @@
`timescale 1ns / 1ps
// Classifier: each value runs the 32-step bit-serial divider; the first
// value of a pass runs it twice, first to derive the bucket width. A new
// value is taken only once the previous one has been pushed to the queue.
// Last value: count update, a read and a check per bucket scanned, multiply,
// result load, then a histogram clear during which no value is taken.
// Reset: synchronous active low; a sweep clears all NUM_BUCKETS entries.
// ----------------------------------------------------------------------------
// bucket_select_pass
// One pass of bucket selection for the k-th smallest value.
// ----------------------------------------------------------------------------
module bucket_select_pass #(
    parameter int NUM_BUCKETS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsp_chan_if.sink    i_in_ch,
    bsp_chan_if.source  o_out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int QW    = IDX_W + 33;

    logic [31:0] r_range_begin;
    logic [31:0] r_range_end;
    logic [8:0]  r_bucket_count;
    logic [31:0] r_target_rank;

    logic [16:0]      w_n;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_push;
    logic             w_pop;
    logic             w_back_pop;
    logic [QW-1:0]    w_push_entry;
    logic [QW-1:0]    w_pop_entry;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_clearing;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_begin  <= bsp_pkg::RST_RANGE_BEGIN;
            r_range_end    <= bsp_pkg::RST_RANGE_END;
            r_bucket_count <= bsp_pkg::RST_BUCKET_COUNT;
            r_target_rank  <= bsp_pkg::RST_TARGET_RANK;
        end else if (i_cfg_we) begin
            unique case (bsp_pkg::t_cfg_idx'(i_cfg_idx))
                bsp_pkg::CFG_RANGE_BEGIN:  r_range_begin  <= i_cfg_wdata;
                bsp_pkg::CFG_RANGE_END:    r_range_end    <= i_cfg_wdata;
                bsp_pkg::CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_wdata[8:0];
                bsp_pkg::CFG_TARGET_RANK:  r_target_rank  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Buckets in use: at least one, at most NUM_BUCKETS
    always_comb begin
        w_n = 17'(r_bucket_count);
        if (w_n == 17'd0) begin
            w_n = 17'd1;
        end
        if (w_n > 17'(NUM_BUCKETS)) begin
            w_n = 17'(NUM_BUCKETS);
        end
    end
    assign w_last_idx = IDX_W'(w_n - 17'd1);

    assign w_pop = !w_q_empty && w_back_pop;

    bsp_front #(
        .IDX_W (IDX_W),
        .QW    (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (i_in_ch),
        .i_range_begin (r_range_begin),
        .i_range_end   (r_range_end),
        .i_last_idx    (w_last_idx),
        .i_clearing    (w_clearing),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    bsp_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_entry),
        .i_pop   (w_pop),
        .o_rdata (w_pop_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    bsp_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .IDX_W       (IDX_W),
        .QW          (QW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (!w_q_empty),
        .i_entry       (w_pop_entry),
        .o_pop         (w_back_pop),
        .i_range_begin (r_range_begin),
        .i_target_rank (r_target_rank),
        .i_last_idx    (w_last_idx),
        .o_clearing    (w_clearing),
        .o_out_ch      (o_out_ch)
    );
endmodule

@@ sim/bsp_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_result_checker
// Watches the value and result channels and the register port of the bucket
// select pass block, keeps its own histogram and registers, works out the
// result of each pass on its last beat and compares every result beat, field
// by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module bsp_result_checker #(
    parameter int NUM_BUCKETS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsp_chan_if         in_mon,
    bsp_chan_if         out_mon,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] reg_begin;
    logic [31:0] reg_end;
    logic [8:0]  reg_count;
    logic [31:0] reg_rank;

    logic [31:0] hist [NUM_BUCKETS];
    logic [31:0] width_latched;
    logic        pass_active;

    bsp_pkg::t_out_item pass_results_q[$];
    int                 fails;

    // Number of buckets actually in use for the current register setting
    function automatic int buckets_used(logic [8:0] cnt);
        int n;
        n = int'(cnt);
        if (n == 0) n = 1;
        if (n > NUM_BUCKETS) n = NUM_BUCKETS;
        return n;
    endfunction

    // Bin one value; on the last beat of a pass, scan and queue the result
    task automatic bin_value(bsp_pkg::t_in_item beat);
        int                 n;
        int                 idx;
        int                 tgt;
        logic [31:0]        w;
        logic [31:0]        rank;
        logic [63:0]        running;
        logic [63:0]        prefix;
        logic               hit;
        bsp_pkg::t_out_item res;
        n = buckets_used(reg_count);
        if (!pass_active) begin
            w = (reg_end - reg_begin) / n;
            width_latched = (w == 0) ? 32'd1 : w;
            pass_active = 1'b1;
        end
        idx = (beat.value - reg_begin) / width_latched;
        if (idx >= n || idx < 0) idx = n - 1;
        if (hist[idx] != bsp_pkg::CNT_MAX) hist[idx] = hist[idx] + 1;
        if (beat.last) begin
            rank = (reg_rank == 0) ? 32'd1 : reg_rank;
            running = 0;
            prefix = 0;
            tgt = n - 1;
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
                prefix = running;
                running = running + hist[i];
                if (running >= {32'd0, rank}) begin
                    tgt = i;
                    hit = 1'b1;
                    break;
                end
            end
            res.target_bucket   = tgt[7:0];
            res.rank_in_bucket  = rank - prefix[31:0];
            res.bucket_size     = hist[tgt];
            res.sub_range_begin = reg_begin + tgt * width_latched;
            res.sub_range_end   = res.sub_range_begin + width_latched;
            res.found           = hit;
            pass_results_q.push_back(res);
            for (int i = 0; i < NUM_BUCKETS; i++) hist[i] = '0;
            pass_active = 1'b0;
        end
    endtask

    task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
                     $time, field, exp_v, act_v);
            fails++;
        end
    endtask

    // Compare one result beat against the oldest predicted pass result
    task automatic check_result(bsp_pkg::t_out_item got);
        bsp_pkg::t_out_item want;
        if (pass_results_q.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, got %p", $time, got);
            fails++;
        end else begin
            want = pass_results_q.pop_front();
            report("target_bucket", want.target_bucket, got.target_bucket);
            report("rank_in_bucket", want.rank_in_bucket, got.rank_in_bucket);
            report("bucket_size", want.bucket_size, got.bucket_size);
            report("sub_range_begin", want.sub_range_begin, got.sub_range_begin);
            report("sub_range_end", want.sub_range_end, got.sub_range_end);
            report("found", want.found, got.found);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_begin = bsp_pkg::RST_RANGE_BEGIN;
            reg_end = bsp_pkg::RST_RANGE_END;
            reg_count = bsp_pkg::RST_BUCKET_COUNT;
            reg_rank = bsp_pkg::RST_TARGET_RANK;
            for (int i = 0; i < NUM_BUCKETS; i++) hist[i] = '0;
            width_latched = '0;
            pass_active = 1'b0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (bsp_pkg::t_cfg_idx'(i_cfg_idx))
                    bsp_pkg::CFG_RANGE_BEGIN:  reg_begin = i_cfg_wdata;
                    bsp_pkg::CFG_RANGE_END:    reg_end = i_cfg_wdata;
                    bsp_pkg::CFG_BUCKET_COUNT: reg_count = i_cfg_wdata[8:0];
                    bsp_pkg::CFG_TARGET_RANK:  reg_rank = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) bin_value(in_mon.data);
            if (out_mon.valid && out_mon.ready) check_result(out_mon.data);
        end
        o_pending <= pass_results_q.size();
        o_fail_count <= fails;
    end

    initial begin
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives passes of values into the bucket select pass block: a directed set
// covering the register extremes and corner cases, then random passes under
// random register settings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_BUCKETS   = 256;
    localparam int TARGET_VALUES = 1900;
    localparam int QUIET_VALUES  = 1600;
    localparam int DRAIN_CYCLES  = 400;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 20000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    bsp_chan_if #(.t_payload(bsp_pkg::t_in_item))  in_ch ();
    bsp_chan_if #(.t_payload(bsp_pkg::t_out_item)) out_ch ();

    int fail_count;
    int pending;
    int values_sent;
    int cycles;
    bit no_idle;
    int hold_token;
    int hold_seen;
    int hold_left;
    int gap_left;

    logic [31:0] cur_begin;
    logic [31:0] cur_end;

    bucket_select_pass #(.NUM_BUCKETS(NUM_BUCKETS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    bsp_result_checker #(.NUM_BUCKETS(NUM_BUCKETS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: long hold-off on request, else random stall bursts
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Write one register, then leave the port idle for a cycle
    task automatic cfg_write(bsp_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bsp_pkg::CFG_RANGE_BEGIN) cur_begin = data;
        if (idx == bsp_pkg::CFG_RANGE_END) cur_end = data;
        @(posedge i_clk);
    endtask

    // Drop valid, hold until every predicted result is out and the clear is done
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one value beat, with an optional idle burst before it
    task automatic send_value(logic [31:0] value, logic last);
        bsp_pkg::t_in_item beat;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        beat.value = value;
        beat.last = last;
        in_ch.valid <= 1'b1;
        in_ch.data <= beat;
        do @(posedge i_clk); while (!in_ch.ready);
        values_sent++;
        if (values_sent > QUIET_VALUES) no_idle = 1'b1;
    endtask

    // Pick a value: mostly inside the current range, some at its edges
    function automatic logic [31:0] pick_value();
        logic [31:0] span;
        span = cur_end - cur_begin;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return cur_begin;
            3:       return cur_end;
            4:       return cur_begin + $urandom_range(0, 3);
            default: return cur_begin + $urandom_range(0, span);
        endcase
    endfunction

    task automatic send_pass(int len);
        for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
    endtask

    // Random register setting for the next phase, extremes now and then
    task automatic random_setting(int len);
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] r;
        logic [8:0]  c;
        case ($urandom_range(0, 5))
            0:       begin b = 32'd0; e = 32'hFFFF_FFFF; end
            1:       begin b = $urandom(); e = b - $urandom_range(1, 1000); end
            2:       begin b = $urandom(); e = b + $urandom_range(0, 300); end
            default: begin b = $urandom(); e = b + $urandom(); end
        endcase
        case ($urandom_range(0, 7))
            0:       c = 9'd0;
            1:       c = 9'($urandom_range(257, 511));
            2:       c = 9'd1;
            3:       c = 9'd256;
            default: c = 9'($urandom_range(2, 64));
        endcase
        case ($urandom_range(0, 7))
            0:       r = 32'd0;
            1:       r = 32'hFFFF_FFFF;
            2:       r = 32'(len + $urandom_range(1, 5));
            default: r = 32'($urandom_range(1, len));
        endcase
        cfg_write(bsp_pkg::CFG_RANGE_BEGIN, b);
        cfg_write(bsp_pkg::CFG_RANGE_END, e);
        cfg_write(bsp_pkg::CFG_BUCKET_COUNT, {23'd0, c});
        cfg_write(bsp_pkg::CFG_TARGET_RANK, r);
    endtask

    initial begin
        int phase;
        int len;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bsp_pkg::CFG_RANGE_BEGIN;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        values_sent = 0;
        cycles = 0;
        no_idle = 1'b0;
        hold_token = 0;
        hold_seen = 0;
        hold_left = 0;
        gap_left = 0;
        cur_begin = bsp_pkg::RST_RANGE_BEGIN;
        cur_end = bsp_pkg::RST_RANGE_END;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setting, single-value pass and field extremes
        send_value(32'd0, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'd0, 1'b1);
        wait_drained();
        // Zero bucket count and zero rank
        cfg_write(bsp_pkg::CFG_BUCKET_COUNT, 32'd0);
        cfg_write(bsp_pkg::CFG_TARGET_RANK, 32'd0);
        send_value(32'd5, 1'b0);
        send_value(32'd3, 1'b1);
        wait_drained();
        // Inverted range, too many buckets, rank never reached
        cfg_write(bsp_pkg::CFG_RANGE_BEGIN, 32'hFFFF_FFF0);
        cfg_write(bsp_pkg::CFG_RANGE_END, 32'd16);
        cfg_write(bsp_pkg::CFG_BUCKET_COUNT, 32'd511);
        cfg_write(bsp_pkg::CFG_TARGET_RANK, 32'hFFFF_FFFF);
        send_value(32'hFFFF_FFF0, 1'b0);
        send_value(32'hFFFF_FFF5, 1'b0);
        send_value(32'd0, 1'b0);
        send_value(32'd15, 1'b1);
        wait_drained();
        // One bucket over the full range
        cfg_write(bsp_pkg::CFG_RANGE_BEGIN, 32'd0);
        cfg_write(bsp_pkg::CFG_RANGE_END, 32'hFFFF_FFFF);
        cfg_write(bsp_pkg::CFG_BUCKET_COUNT, 32'd1);
        cfg_write(bsp_pkg::CFG_TARGET_RANK, 32'd2);
        send_value(32'd1, 1'b0);
        send_value(32'd2, 1'b1);
        wait_drained();
        // Empty range forces the width to one
        cfg_write(bsp_pkg::CFG_RANGE_BEGIN, 32'd100);
        cfg_write(bsp_pkg::CFG_RANGE_END, 32'd100);
        cfg_write(bsp_pkg::CFG_BUCKET_COUNT, 32'd256);
        cfg_write(bsp_pkg::CFG_TARGET_RANK, 32'd3);
        send_value(32'd100, 1'b0);
        send_value(32'd101, 1'b0);
        send_value(32'd355, 1'b0);
        send_value(32'd50, 1'b1);

        // Random phases: settle, set registers, run a few passes
        phase = 0;
        while (values_sent < TARGET_VALUES) begin
            wait_drained();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 30);
            random_setting(len);
            if (phase == 4) begin
                // Back up the result side while values keep coming
                hold_token++;
                repeat (6) send_pass($urandom_range(1, 4));
            end
            repeat ($urandom_range(1, 4)) begin
                send_pass(len);
                len = $urandom_range(1, 30);
            end
            phase++;
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
